>>> rtl/lbpc_pkg.sv
// Shared types and constants for the LED blink and pattern controller.
package lbpc_pkg;

  // Fixed field widths of the input word.
  localparam int unsigned FuncW    = 3;
  localparam int unsigned SelW     = 2;
  localparam int unsigned IvalW    = 31;
  localparam int unsigned DataW    = 1 + SelW + IvalW;
  localparam int unsigned DataBytW = ((DataW + 7) / 8) * 8;

  // Pattern period after reset, in ticks.
  localparam logic [IvalW-1:0] PeriodReset = IvalW'(300);

  // Function codes of an input word.
  typedef enum logic [FuncW-1:0] {
    FUNC_TICK    = 3'd0,
    FUNC_ON      = 3'd1,
    FUNC_OFF     = 3'd2,
    FUNC_BLINK   = 3'd3,
    FUNC_CHASE   = 3'd4,
    FUNC_ALT     = 3'd5,
    FUNC_PAT_OFF = 3'd6
  } func_e;

  // Running pattern, as reported on the output.
  typedef enum logic [1:0] {
    PAT_NONE  = 2'd0,
    PAT_CHASE = 2'd1,
    PAT_ALT   = 2'd2
  } pat_kind_e;

  // Registered input word.
  typedef struct packed {
    logic [IvalW-1:0] ival;
    logic [SelW-1:0]  sel;
    logic             all_leds;
    logic [FuncW-1:0] func;
  } in_item_t;

  // Per-LED command, already resolved for that LED.
  typedef struct packed {
    logic tick;
    logic drive_on;
    logic drive_off;
    logic blink;
  } lane_cmd_t;

  // Pattern sequencer command.
  typedef struct packed {
    logic tick;
    logic start;
    logic alt;
    logic stop;
  } pat_cmd_t;

endpackage

>>> rtl/led_blink_pattern_controller.sv
// LED blink and pattern controller: top level with input and result registers.
// Each word passes the input register, one level of decode and counter compare
// logic, then the result register. Throughput: one word per cycle while the result
// side does not stall.
// Reset: asynchronous, active low; all LEDs off, no pattern, pattern period 300,
// default pattern interval 300, both word registers empty.
module led_blink_pattern_controller
  import lbpc_pkg::*;
#(
  parameter int unsigned LED_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: default pattern interval.
  input  logic                 cfg_we_i,
  input  logic [IvalW-1:0]     cfg_wdata_i,
  // Input words.
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // all_leds[0], led_select[2:1], interval[33:3], zero padding above
  input  logic [DataBytW-1:0]  s_axis_tdata_i,
  // func[2:0]
  input  logic [FuncW-1:0]     s_axis_tuser_i,
  // Result words.
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // led_levels[LED_COUNT-1:0], error, pattern_active[1:0], zero padding above
  output logic [((LED_COUNT + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);

  localparam int unsigned OutW   = LED_COUNT + 3;
  localparam int unsigned OutBytW = ((OutW + 7) / 8) * 8;

  logic                 in_valid_q;
  in_item_t             in_q;
  logic                 out_valid_q;
  logic [OutW-1:0]      out_data_q;
  logic [LED_COUNT-1:0] levels_q;
  logic [LED_COUNT-1:0] levels_d;
  logic [IvalW-1:0]     dflt_q;
  logic                 advance;
  logic                 err;
  logic                 blink_ok;
  logic                 is_tick;
  logic                 is_on;
  logic                 is_off;
  logic                 is_blink;
  logic                 is_start;
  logic                 is_pat_off;
  lane_cmd_t            lane_cmd [LED_COUNT];
  logic [LED_COUNT-1:0] toggles;
  pat_cmd_t             pat_cmd;
  logic                 pat_fire;
  logic [LED_COUNT-1:0] pat_levels;
  pat_kind_e            pat_kind_d;

  // Handshake: the input register refills whenever its word moves on.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutBytW'(out_data_q);

  // Function decode.
  always_comb begin
    is_tick    = 1'b0;
    is_on      = 1'b0;
    is_off     = 1'b0;
    is_blink   = 1'b0;
    is_start   = 1'b0;
    is_pat_off = 1'b0;
    unique case (in_q.func)
      FUNC_TICK:    is_tick    = 1'b1;
      FUNC_ON:      is_on      = 1'b1;
      FUNC_OFF:     is_off     = 1'b1;
      FUNC_BLINK:   is_blink   = 1'b1;
      FUNC_CHASE:   is_start   = 1'b1;
      FUNC_ALT:     is_start   = 1'b1;
      FUNC_PAT_OFF: is_pat_off = 1'b1;
      default:      ;
    endcase
  end

  // A blink needs a nonzero interval and an LED that exists.
  assign blink_ok = is_blink && (in_q.ival != '0) && (int'(in_q.sel) < LED_COUNT);
  assign err      = is_blink && !blink_ok;

  // Per-LED commands and lanes.
  for (genvar g = 0; g < LED_COUNT; g++) begin : g_lane
    logic hit;
    assign hit = in_q.all_leds || (int'(in_q.sel) == g);
    assign lane_cmd[g].tick      = is_tick;
    assign lane_cmd[g].drive_on  = is_on && hit;
    assign lane_cmd[g].drive_off = (is_off && hit) || is_start || is_pat_off;
    assign lane_cmd[g].blink     = blink_ok && (int'(in_q.sel) == g);

    lbpc_blink_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .step_i   (advance),
      .cmd_i    (lane_cmd[g]),
      .ival_i   (in_q.ival),
      .toggle_o (toggles[g])
    );
  end

  // Pattern sequencer.
  assign pat_cmd.tick  = is_tick;
  assign pat_cmd.start = is_start;
  assign pat_cmd.alt   = (in_q.func == FUNC_ALT);
  assign pat_cmd.stop  = is_on || is_off || blink_ok || is_pat_off;

  lbpc_pattern #(
    .LED_COUNT (LED_COUNT)
  ) u_pattern (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .cmd_i    (pat_cmd),
    .ival_i   (in_q.ival),
    .dflt_i   (dflt_q),
    .fire_o   (pat_fire),
    .levels_o (pat_levels),
    .kind_d_o (pat_kind_d)
  );

  // LED levels after the current word.
  always_comb begin
    levels_d = levels_q;
    for (int i = 0; i < LED_COUNT; i++) begin
      if (lane_cmd[i].drive_on || lane_cmd[i].blink) begin
        levels_d[i] = 1'b1;
      end else if (lane_cmd[i].drive_off) begin
        levels_d[i] = 1'b0;
      end
    end
    if (is_tick) begin
      levels_d = pat_fire ? pat_levels : (levels_q ^ toggles);
    end
  end

  // Input register, levels, result register and default pattern interval.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      levels_q    <= '0;
      dflt_q      <= PeriodReset;
    end else begin
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        levels_q    <= levels_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= in_item_t'({s_axis_tdata_i[DataW-1:0], s_axis_tuser_i});
    end
    if (advance) begin
      out_data_q <= {pat_kind_d, err, levels_d};
    end
  end

  // A pattern start always shows all LEDs dark.
  a_start_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && is_start |=> (out_data_q[LED_COUNT-1:0] == '0))
    else $error("pattern start left an LED lit");

  // A stalled input word is held, not dropped.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q)
    else $error("input word lost while stalled");

  // Backpressure only when both registers are full.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with a free register");

  // A rejected blink neither starts nor stops a pattern.
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && err |-> !pat_cmd.start && !pat_cmd.stop)
    else $error("rejected blink changed state");

endmodule

>>> rtl/lbpc_blink_lane.sv
// One LED's mode and blink counter.
module lbpc_blink_lane
  import lbpc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  lane_cmd_t        cmd_i,
  input  logic [IvalW-1:0] ival_i,
  output logic             toggle_o
);

  typedef enum logic [1:0] {
    ST_DARK     = 2'd0,
    ST_STEADY   = 2'd1,
    ST_BLINKING = 2'd2
  } mode_e;

  mode_e            mode_q;
  logic [IvalW-1:0] interval_q;
  logic [IvalW-1:0] elapsed_q;
  logic [IvalW-1:0] elapsed_inc;

  // The count wraps within its width, then is compared to the interval.
  assign elapsed_inc = elapsed_q + IvalW'(1);
  assign toggle_o    = cmd_i.tick && (mode_q == ST_BLINKING) && (elapsed_inc >= interval_q);

  // Mode and counter update for each processed word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ST_DARK;
      interval_q <= '0;
      elapsed_q  <= '0;
    end else if (step_i) begin
      if (cmd_i.drive_on) begin
        mode_q <= ST_STEADY;
      end else if (cmd_i.drive_off) begin
        mode_q <= ST_DARK;
      end else if (cmd_i.blink) begin
        mode_q     <= ST_BLINKING;
        interval_q <= ival_i;
        elapsed_q  <= '0;
      end else if (cmd_i.tick && (mode_q == ST_BLINKING)) begin
        elapsed_q <= toggle_o ? '0 : elapsed_inc;
      end
    end
  end

endmodule

>>> rtl/lbpc_pattern.sv
// Chase and alternate pattern sequencer with its step timer.
module lbpc_pattern
  import lbpc_pkg::*;
#(
  parameter int unsigned LED_COUNT = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  pat_cmd_t             cmd_i,
  input  logic [IvalW-1:0]     ival_i,
  input  logic [IvalW-1:0]     dflt_i,
  output logic                 fire_o,
  output logic [LED_COUNT-1:0] levels_o,
  output pat_kind_e            kind_d_o
);

  localparam int unsigned PosW = $clog2(LED_COUNT);

  pat_kind_e        kind_q;
  logic [IvalW-1:0] period_q;
  logic [IvalW-1:0] elapsed_q;
  logic [PosW-1:0]  pos_q;
  logic             phase_q;
  logic [IvalW-1:0] elapsed_inc;
  logic             phase_nxt;

  assign elapsed_inc = elapsed_q + IvalW'(1);
  assign fire_o      = cmd_i.tick && (kind_q != PAT_NONE) && (elapsed_inc >= period_q);
  assign phase_nxt   = ~phase_q;

  // Levels driven when the pattern steps.
  always_comb begin
    levels_o = '0;
    if (kind_q == PAT_CHASE) begin
      levels_o = LED_COUNT'(1) << pos_q;
    end else begin
      for (int i = 0; i < LED_COUNT; i++) begin
        levels_o[i] = (i % 2 == 0) ? phase_nxt : phase_q;
      end
    end
  end

  // Pattern kind after the current word.
  always_comb begin
    kind_d_o = kind_q;
    if (cmd_i.start) begin
      kind_d_o = cmd_i.alt ? PAT_ALT : PAT_CHASE;
    end else if (cmd_i.stop) begin
      kind_d_o = PAT_NONE;
    end
  end

  // Timer and step state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= PAT_NONE;
      period_q  <= PeriodReset;
      elapsed_q <= '0;
      pos_q     <= '0;
      phase_q   <= 1'b0;
    end else if (step_i) begin
      kind_q <= kind_d_o;
      if (cmd_i.start) begin
        period_q  <= (ival_i != '0) ? ival_i : dflt_i;
        elapsed_q <= '0;
        pos_q     <= '0;
        phase_q   <= 1'b0;
      end else if (cmd_i.tick && (kind_q != PAT_NONE)) begin
        elapsed_q <= fire_o ? '0 : elapsed_inc;
        if (fire_o) begin
          if (kind_q == PAT_CHASE) begin
            pos_q <= (pos_q == PosW'(LED_COUNT - 1)) ? '0 : pos_q + PosW'(1);
          end else begin
            phase_q <= phase_nxt;
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the LED blink and pattern controller.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbpc_pkg::*;

  localparam int unsigned LedCount   = 4;
  localparam int unsigned OutW       = ((LedCount + 3 + 7) / 8) * 8;
  localparam int unsigned WatchLimit = 2000;
  localparam int unsigned PhaseWords = 225;
  localparam logic [IvalW-1:0] IvalMax = {IvalW{1'b1}};
  // Function code that the block leaves without any effect.
  localparam logic [FuncW-1:0] FuncUnused = 3'd7;

  typedef enum logic [1:0] {
    LANE_OFF   = 2'd0,
    LANE_ON    = 2'd1,
    LANE_BLINK = 2'd2
  } lane_mode_e;

  // Result word layout, highest field first.
  typedef struct packed {
    pat_kind_e           pat;
    logic                err;
    logic [LedCount-1:0] levels;
  } led_result_t;

  // One row of the directed stimulus table.
  typedef struct {
    in_item_t    word;
    bit          typed;
    led_result_t want;
  } lead_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [IvalW-1:0]    cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [DataBytW-1:0] s_axis_tdata_i = '0;
  logic [FuncW-1:0]    s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutW-1:0]     m_axis_tdata_o;

  // Side information traveling with the word currently offered.
  bit                  word_typed = 1'b0;
  led_result_t         word_want = '0;

  // Predictor state: per-LED lanes, levels and the pattern sequencer.
  lane_mode_e          lane_mode [LedCount];
  logic [IvalW-1:0]    lane_period [LedCount];
  logic [IvalW-1:0]    lane_count [LedCount];
  logic [LedCount-1:0] lit;
  pat_kind_e           run_kind;
  logic [IvalW-1:0]    run_period;
  logic [IvalW-1:0]    run_count;
  logic [IvalW-1:0]    dflt_period;
  logic [$clog2(LedCount)-1:0] chase_at;
  logic                alt_phase;

  led_result_t         levels_due [$];
  lead_row_t           lead_rows [$];
  logic [IvalW-1:0]    period_plan [6] = '{PeriodReset, 1, 0, 3, IvalMax, 2};

  bit                  calm = 1'b0;
  int unsigned         mismatch_count = 0;
  int unsigned         results_seen = 0;
  int unsigned         words_sent = 0;
  int unsigned         ticks_sent = 0;
  int unsigned         blinks_refused = 0;
  int unsigned         quiet_cycles = 0;

  led_blink_pattern_controller #(
    .LED_COUNT(LedCount)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #10 clk_i = ~clk_i;

  // Put one LED into a steady on or off mode and set its level to match.
  function automatic void drive_lane(int unsigned idx, lane_mode_e m);
    lane_mode[idx] = m;
    lit[idx] = (m == LANE_ON);
  endfunction

  // Apply one input word to the predictor state and return the expected result.
  function automatic led_result_t predict_leds(in_item_t w);
    led_result_t r;
    r.err = 1'b0;
    case (w.func)
      FUNC_TICK: begin
        for (int i = 0; i < LedCount; i++) begin
          if (lane_mode[i] == LANE_BLINK) begin
            lane_count[i] = lane_count[i] + 1'b1;
            if (lane_count[i] >= lane_period[i]) begin
              lit[i] = ~lit[i];
              lane_count[i] = '0;
            end
          end
        end
        if (run_kind != PAT_NONE) begin
          run_count = run_count + 1'b1;
          if (run_count >= run_period) begin
            run_count = '0;
            if (run_kind == PAT_CHASE) begin
              lit = '0;
              lit[chase_at] = 1'b1;
              chase_at = (chase_at == LedCount - 1) ? '0 : chase_at + 1'b1;
            end else begin
              alt_phase = ~alt_phase;
              for (int i = 0; i < LedCount; i++) begin
                lit[i] = (i % 2 == 0) ? alt_phase : ~alt_phase;
              end
            end
          end
        end
      end
      FUNC_ON, FUNC_OFF: begin
        run_kind = PAT_NONE;
        if (w.all_leds) begin
          for (int i = 0; i < LedCount; i++) begin
            drive_lane(i, (w.func == FUNC_ON) ? LANE_ON : LANE_OFF);
          end
        end else if (w.sel < LedCount) begin
          drive_lane(w.sel, (w.func == FUNC_ON) ? LANE_ON : LANE_OFF);
        end
      end
      FUNC_BLINK: begin
        if (w.ival == '0 || w.sel >= LedCount) begin
          r.err = 1'b1;
        end else begin
          run_kind = PAT_NONE;
          lane_mode[w.sel] = LANE_BLINK;
          lane_period[w.sel] = w.ival;
          lane_count[w.sel] = '0;
          lit[w.sel] = 1'b1;
        end
      end
      FUNC_CHASE, FUNC_ALT: begin
        run_period = (w.ival != '0) ? w.ival : dflt_period;
        run_count = '0;
        chase_at = '0;
        alt_phase = 1'b0;
        for (int i = 0; i < LedCount; i++) begin
          drive_lane(i, LANE_OFF);
        end
        run_kind = (w.func == FUNC_CHASE) ? PAT_CHASE : PAT_ALT;
      end
      FUNC_PAT_OFF: begin
        run_kind = PAT_NONE;
        for (int i = 0; i < LedCount; i++) begin
          drive_lane(i, LANE_OFF);
        end
      end
      default: begin
      end
    endcase
    r.levels = lit;
    r.pat = run_kind;
    return r;
  endfunction

  // Print one mismatch line and count it.
  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("ERROR: result word %0d, %s: got %0h, expected %0h",
             results_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(input logic [FuncW-1:0] fn, input logic to_all,
                         input logic [SelW-1:0] sel, input logic [IvalW-1:0] ival,
                         input bit typed, input logic [LedCount-1:0] lv,
                         input logic err, input pat_kind_e pat);
    lead_row_t row;
    row.word = '{ival: ival, sel: sel, all_leds: to_all, func: fn};
    row.typed = typed;
    row.want = '{pat: pat, err: err, levels: lv};
    lead_rows.push_back(row);
  endtask

  // Offer one word, after a random gap outside the calm phase, and hold it until it is taken.
  task automatic send_word(input in_item_t w, input bit typed, input led_result_t want);
    while (!calm && $urandom_range(99) < 30) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= DataBytW'({w.ival, w.sel, w.all_leds});
    s_axis_tuser_i <= w.func;
    word_typed <= typed;
    word_want <= want;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Stop sending and wait until every expected result word has come back.
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (levels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_default_period(input logic [IvalW-1:0] v);
    quiesce();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dflt_period = v;
  endtask

  // Mostly ticks and small intervals so blinks and patterns actually step.
  function automatic in_item_t random_word();
    in_item_t w;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) w.func = FUNC_TICK;
    else if (roll < 53) w.func = FUNC_ON;
    else if (roll < 60) w.func = FUNC_OFF;
    else if (roll < 75) w.func = FUNC_BLINK;
    else if (roll < 83) w.func = FUNC_CHASE;
    else if (roll < 91) w.func = FUNC_ALT;
    else if (roll < 97) w.func = FUNC_PAT_OFF;
    else w.func = FuncUnused;
    w.all_leds = 1'($urandom_range(1));
    w.sel = SelW'($urandom_range(LedCount - 1));
    case ($urandom_range(9))
      0: w.ival = '0;
      1: w.ival = IvalW'($urandom);
      2: w.ival = IvalMax;
      default: w.ival = IvalW'($urandom_range(6, 1));
    endcase
    return w;
  endfunction

  // The result side stalls at random except during the calm phase.
  always @(posedge clk_i) begin
    m_axis_tready_i <= calm || ($urandom_range(99) >= 30);
  end

  // Check result words against the oldest expectation and predict accepted input words.
  always @(posedge clk_i) begin
    led_result_t got;
    led_result_t want;
    led_result_t fresh;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = led_result_t'(m_axis_tdata_o[$bits(led_result_t)-1:0]);
      if (levels_due.size() == 0) begin
        flag_mismatch("result word with nothing pending", got, 0);
      end else begin
        want = levels_due.pop_front();
        if (got.levels !== want.levels) flag_mismatch("led_levels", got.levels, want.levels);
        if (got.err !== want.err) flag_mismatch("error", got.err, want.err);
        if (got.pat !== want.pat) flag_mismatch("pattern_active", got.pat, want.pat);
      end
      results_seen++;
    end
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      fresh = predict_leds(in_item_t'({s_axis_tdata_i[DataW-1:0], s_axis_tuser_i}));
      levels_due.push_back(word_typed ? word_want : fresh);
      words_sent++;
      if (s_axis_tuser_i == FUNC_TICK) ticks_sent++;
      if (fresh.err) blinks_refused++;
    end
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Watchdog on cycles in which no word moves on either side.
  initial begin
    while (quiet_cycles < WatchLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    for (int i = 0; i < LedCount; i++) begin
      lane_mode[i] = LANE_OFF;
      lane_period[i] = '0;
      lane_count[i] = '0;
    end
    lit = '0;
    run_kind = PAT_NONE;
    run_period = PeriodReset;
    run_count = '0;
    dflt_period = PeriodReset;
    chase_at = '0;
    alt_phase = 1'b0;

    // Directed words: steady drive, blink edge cases, both patterns, unused code.
    add_row(FUNC_TICK,    0, 0, 0,       1, 4'h0, 0, PAT_NONE);
    add_row(FUNC_ON,      1, 0, 0,       1, 4'hF, 0, PAT_NONE);
    add_row(FUNC_OFF,     0, 2, 0,       1, 4'hB, 0, PAT_NONE);
    add_row(FUNC_OFF,     1, 0, 0,       1, 4'h0, 0, PAT_NONE);
    add_row(FUNC_ON,      0, 0, 0,       1, 4'h1, 0, PAT_NONE);
    add_row(FUNC_BLINK,   0, 1, 0,       1, 4'h1, 1, PAT_NONE);
    add_row(FUNC_BLINK,   0, 3, 1,       1, 4'h9, 0, PAT_NONE);
    add_row(FUNC_TICK,    0, 0, 0,       0, '0, 0, PAT_NONE);
    add_row(FUNC_TICK,    0, 0, 0,       0, '0, 0, PAT_NONE);
    add_row(FUNC_BLINK,   0, 2, IvalMax, 0, '0, 0, PAT_NONE);
    add_row(FUNC_TICK,    0, 0, 0,       0, '0, 0, PAT_NONE);
    add_row(FUNC_CHASE,   0, 0, 0,       1, 4'h0, 0, PAT_CHASE);
    add_row(FuncUnused,   1, 3, IvalMax, 1, 4'h0, 0, PAT_CHASE);
    add_row(FUNC_CHASE,   0, 0, 2,       1, 4'h0, 0, PAT_CHASE);
    repeat (4) add_row(FUNC_TICK, 0, 0, 0, 0, '0, 0, PAT_NONE);
    add_row(FUNC_ALT,     0, 0, 1,       1, 4'h0, 0, PAT_ALT);
    repeat (2) add_row(FUNC_TICK, 0, 0, 0, 0, '0, 0, PAT_NONE);
    add_row(FUNC_ON,      0, 0, 0,       0, '0, 0, PAT_NONE);
    add_row(FUNC_ALT,     1, 3, IvalMax, 1, 4'h0, 0, PAT_ALT);
    add_row(FUNC_OFF,     1, 0, 0,       1, 4'h0, 0, PAT_NONE);
    add_row(FUNC_PAT_OFF, 0, 0, 0,       1, 4'h0, 0, PAT_NONE);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (lead_rows[k]) send_word(lead_rows[k].word, lead_rows[k].typed, lead_rows[k].want);

    // Random phases, each under its own default pattern interval; the first keeps
    // the reset value and the third runs without any idling.
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) quiesce();
      else write_default_period(period_plan[ph]);
      calm = (ph == 2);
      for (int n = 0; n < PhaseWords; n++) send_word(random_word(), 1'b0, '0);
    end
    calm = 1'b0;

    quiesce();
    repeat (8) @(posedge clk_i);
    if (levels_due.size() != 0) flag_mismatch("results never returned", levels_due.size(), 0);
    $display("Covered %0d words (%0d ticks, %0d refused blinks) under %0d interval settings.",
             words_sent, ticks_sent, blinks_refused, 6);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lbpc_pkg.sv
rtl/lbpc_blink_lane.sv
rtl/lbpc_pattern.sv
rtl/led_blink_pattern_controller.sv
verif/tb_top.sv
